FILE: rtl/smsd_pkg.sv
`default_nettype none

package smsd_pkg;

  localparam int WINDOW      = 9;
  localparam int SAMPLE_BITS = 16;
  localparam int FIELD_W     = 16;
  localparam int MED_RANK    = (WINDOW - 1) / 2;
  localparam int AGE_W       = $clog2(WINDOW);
  localparam int FILL_W      = $clog2(WINDOW);
  localparam int SUM_W       = SAMPLE_BITS + $clog2(WINDOW);
  localparam int THR_W       = SAMPLE_BITS + 1 + $clog2(WINDOW);

  typedef logic [SAMPLE_BITS-1:0] sample_t;
  typedef logic [FIELD_W-1:0]     field_t;
  typedef logic [AGE_W-1:0]       age_t;
  typedef logic [FILL_W-1:0]      fill_t;
  typedef logic [SUM_W-1:0]       sum_t;
  typedef logic [THR_W-1:0]       thr_t;

  // One entry of the sorted window: its value and how many samples ago it came in.
  typedef struct packed {
    sample_t val;
    age_t    age;
  } cell_t;

  // What a cell hands to the next one up the chain.
  typedef struct packed {
    cell_t r;        // this slot's entry once the oldest has been dropped
    logic  lt;       // that entry ranks below the new sample
    logic  shifted;  // the oldest entry sits at or below this slot
  } link_t;

endpackage

`default_nettype wire

FILE: rtl/smsd_if.sv
`default_nettype none

interface smsd_in_if;
  logic                  valid;
  logic                  ready;
  smsd_pkg::field_t      sample;
  logic                  record_start;

  modport source (output valid, sample, record_start, input ready);
  modport sink   (input valid, sample, record_start, output ready);
endinterface

interface smsd_out_if;
  logic                  valid;
  logic                  ready;
  smsd_pkg::field_t      filtered;
  logic                  spike;
  logic                  warming_up;

  modport source (output valid, filtered, spike, warming_up, input ready);
  modport sink   (input valid, filtered, spike, warming_up, output ready);
endinterface

`default_nettype wire

FILE: rtl/smsd_cell.sv
`default_nettype none

module smsd_cell (
  input  logic            clk,
  input  logic            rst,
  input  logic            load,
  input  smsd_pkg::sample_t x,
  input  smsd_pkg::age_t  rst_age,
  input  smsd_pkg::cell_t up,
  input  logic            up_ok,
  input  smsd_pkg::link_t lo,
  output smsd_pkg::link_t hi,
  output smsd_pkg::cell_t cur,
  output smsd_pkg::sample_t old_val
);
  import smsd_pkg::*;

  cell_t cell_next;
  logic  old;

  always_comb begin
    old        = (cur.age == age_t'(WINDOW - 1));
    hi.shifted = lo.shifted | old;
    // close the gap left by the dropped entry
    hi.r       = hi.shifted ? up : cur;
    hi.lt      = up_ok & (hi.r.val < x);
    old_val    = old ? cur.val : '0;
  end

  always_comb begin
    if (hi.lt) begin
      cell_next = '{val: hi.r.val, age: hi.r.age + age_t'(1)};
    end else if (lo.lt) begin
      cell_next = '{val: x, age: '0};
    end else begin
      cell_next = '{val: lo.r.val, age: lo.r.age + age_t'(1)};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur <= '{val: '0, age: rst_age};
    end else if (load) begin
      cur <= cell_next;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/sliding_median_spike_detector.sv
// Sliding-window median filter with spike flag.
// samples: one unsigned sample per transfer plus record_start, which restarts
//   warm-up on that sample. results: one transfer per sample, in order.
// During warm-up (the first WINDOW-1 samples of a record) filtered is the raw
//   sample, warming_up is 1 and spike is 0. After that filtered is the lower
//   median of the last WINDOW samples and spike is 1 when three times the
//   median lies below twice the floored window average.
// The window is a row of WINDOW cells kept in ascending order; every sample
//   drops the oldest entry and inserts itself as it is taken, with a running sum
//   beside the row. A second register stage ranks the median against the sum.
// A sample is registered into the cell row and middle stage, then its result into the output register.
// Throughput: one sample per cycle while results are taken.
// Reset clears the window to zeros, the sum and the warm-up count, and
//   empties both stages; a stream that starts without record_start is a
//   record that began at reset.
// When results stalls the output register holds, one more sample may enter
//   the middle stage, and samples.ready then drops until results moves.
`default_nettype none

module sliding_median_spike_detector (
  input  logic        clk,
  input  logic        rst,
  smsd_in_if.sink     samples,
  smsd_out_if.source  results
);
  import smsd_pkg::*;

  cell_t   cells   [WINDOW];
  link_t   links   [WINDOW+1];
  sample_t old_vals[WINDOW];

  sample_t x;
  logic    accept;
  logic    out_free;
  sample_t oldest;
  fill_t   fill;
  fill_t   fill_base;
  logic    warm;
  sum_t    sum;

  logic    s1_valid;
  logic    s1_warm;
  sample_t s1_sample;

  sample_t med;
  logic [SAMPLE_BITS:0] k;
  thr_t    thr;
  logic    spike_now;

  assign x        = sample_t'(samples.sample);
  assign out_free = !results.valid || results.ready;
  assign samples.ready = !s1_valid || out_free;
  assign accept   = samples.valid && samples.ready;

  assign links[0] = '{r: '0, lt: 1'b1, shifted: 1'b0};

  genvar gi;
  generate
    for (gi = 0; gi < WINDOW; gi++) begin : g_cell
      if (gi < WINDOW - 1) begin : g_mid
        smsd_cell u_cell (
          .clk     (clk),
          .rst     (rst),
          .load    (accept),
          .x       (x),
          .rst_age (age_t'(gi)),
          .up      (cells[gi+1]),
          .up_ok   (1'b1),
          .lo      (links[gi]),
          .hi      (links[gi+1]),
          .cur     (cells[gi]),
          .old_val (old_vals[gi])
        );
      end else begin : g_top
        smsd_cell u_cell (
          .clk     (clk),
          .rst     (rst),
          .load    (accept),
          .x       (x),
          .rst_age (age_t'(gi)),
          .up      (cells[gi]),
          .up_ok   (1'b0),
          .lo      (links[gi]),
          .hi      (links[gi+1]),
          .cur     (cells[gi]),
          .old_val (old_vals[gi])
        );
      end
    end
  endgenerate

  always_comb begin
    oldest = '0;
    for (int i = 0; i < WINDOW; i++) begin
      oldest = oldest | old_vals[i];
    end
  end

  always_comb begin
    fill_base = samples.record_start ? '0 : fill;
    warm      = (fill_base < fill_t'(WINDOW - 1));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill <= '0;
      sum  <= '0;
    end else if (accept) begin
      if (warm) begin
        fill <= fill_base + fill_t'(1);
      end else begin
        fill <= fill_base;
      end
      sum <= sum + sum_t'(x) - sum_t'(oldest);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (out_free) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_warm   <= warm;
      s1_sample <= x;
    end
  end

  // floor(sum/WINDOW) > 1.5*med  <=>  sum >= WINDOW*(med + med/2 + 1)
  always_comb begin
    med       = cells[MED_RANK].val;
    k         = {1'b0, med} + {2'b00, med[SAMPLE_BITS-1:1]} + (SAMPLE_BITS+1)'(1);
    thr       = thr_t'(k) * thr_t'(WINDOW);
    spike_now = (thr_t'(sum) >= thr);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      results.valid <= 1'b0;
    end else if (out_free) begin
      results.valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free && s1_valid) begin
      results.filtered   <= s1_warm ? field_t'(s1_sample) : field_t'(med);
      results.spike      <= s1_warm ? 1'b0 : spike_now;
      results.warming_up <= s1_warm;
    end
  end

`ifndef SYNTHESIS
  logic [WINDOW-1:0] old_vec;
  logic [WINDOW-2:0] order_ok;

  always_comb begin
    for (int i = 0; i < WINDOW; i++) begin
      old_vec[i] = (cells[i].age == age_t'(WINDOW - 1));
    end
    for (int i = 0; i < WINDOW - 1; i++) begin
      order_ok[i] = (cells[i].val <= cells[i+1].val);
    end
  end

  a_one_oldest: assert property (@(posedge clk) disable iff (rst) $onehot(old_vec))
    else $error("window does not hold exactly one oldest entry");

  a_sorted: assert property (@(posedge clk) disable iff (rst) &order_ok)
    else $error("cell row out of ascending order");

  a_fill_range: assert property (@(posedge clk) disable iff (rst)
      fill <= fill_t'(WINDOW - 1))
    else $error("warm-up count beyond window");

  a_warm_no_spike: assert property (@(posedge clk) disable iff (rst)
      results.valid && results.warming_up |-> !results.spike)
    else $error("spike raised during warm-up");

  a_stage_held: assert property (@(posedge clk) disable iff (rst)
      s1_valid && !out_free |=> s1_valid && $stable(s1_sample))
    else $error("middle stage lost a sample under stall");
`endif

endmodule

`default_nettype wire
